@@ hw/rtl/tkn_pkg.sv @@
// Shared types and constants for the top-k nearest neighbour search block
package tkn_pkg;

  localparam int MAX_DIM = 1024;
  localparam int MAX_K   = 64;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int K_W     = $clog2(MAX_K) + 1;
  localparam int LEN_W   = 11;
  localparam int VAL_W   = 16;
  localparam int ID_W    = 16;
  localparam int DIST_W  = 32;
  localparam int DIFF_W  = 43;
  localparam int DOT_W   = 42;
  localparam int NORM_W  = 41;
  localparam int MAG_W   = 41;
  localparam int PROD_W  = 82;
  localparam int ROOT_W  = PROD_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int NUM_W   = MAG_W + 30;
  localparam int STEP_W  = 7;
  localparam int NB_LO_W = 21;

  localparam logic [DIST_W-1:0] ONE_Q30  = 32'h4000_0000;
  localparam logic [ROOT_W-1:0] EPS_ROOT = 41'd16;

  typedef enum logic [1:0] {
    KIND_QUERY = 2'd0,
    KIND_CAND  = 2'd1,
    KIND_FLUSH = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam logic [1:0] REG_METRIC = 2'd0;
  localparam logic [1:0] REG_TOPK   = 2'd1;
  localparam logic [1:0] REG_LEN    = 2'd2;

  typedef struct packed {
    logic ins;
    logic trim;
    logic pop;
  } cell_ctrl_t;

  typedef struct packed {
    logic              valid;
    logic              keep;
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] dst;
  } cell_out_t;

endpackage

@@ hw/rtl/tkn_cell.sv @@
// One entry of the sorted neighbour list, shifting to its neighbours on insert and pop
module tkn_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tkn_pkg::cell_ctrl_t       ctrl,
  input  logic                      beyond_k,
  input  logic [tkn_pkg::ID_W-1:0]  new_id,
  input  logic [tkn_pkg::DIST_W-1:0] new_dist,
  input  tkn_pkg::cell_out_t        left,
  input  tkn_pkg::cell_out_t        right,
  output tkn_pkg::cell_out_t        cell_o
);

  logic                       valid_r, valid_nxt;
  logic [tkn_pkg::ID_W-1:0]   id_r, id_nxt;
  logic [tkn_pkg::DIST_W-1:0] dist_r, dist_nxt;
  logic                       keep;

  // ties stay ahead of the newcomer
  assign keep = valid_r && (dist_r <= new_dist);

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    dist_nxt  = dist_r;
    priority if (ctrl.pop) begin
      valid_nxt = right.valid;
      id_nxt    = right.id;
      dist_nxt  = right.dst;
    end else if (ctrl.ins) begin
      priority if (beyond_k) begin
        valid_nxt = 1'b0;
      end else if (keep) begin
        valid_nxt = valid_r;
      end else if (left.keep) begin
        valid_nxt = 1'b1;
        id_nxt    = new_id;
        dist_nxt  = new_dist;
      end else begin
        valid_nxt = left.valid;
        id_nxt    = left.id;
        dist_nxt  = left.dst;
      end
    end else if (ctrl.trim && beyond_k) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    id_r   <= id_nxt;
    dist_r <= dist_nxt;
  end

  assign cell_o.valid = valid_r;
  assign cell_o.keep  = keep;
  assign cell_o.id    = id_r;
  assign cell_o.dst   = dist_r;

endmodule

@@ hw/rtl/tkn_cos.sv @@
// Cosine distance unit: split norm product, digit-serial square root and long division
module tkn_cos (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tkn_pkg::NORM_W-1:0]  norm_a,
  input  logic [tkn_pkg::NORM_W-1:0]  norm_b,
  input  logic signed [tkn_pkg::DOT_W-1:0] dot,
  output logic                        done,
  output logic [tkn_pkg::DIST_W-1:0]  dist_o
);

  typedef enum logic [6:0] {
    CS_IDLE = 7'b0000001,
    CS_MUL0 = 7'b0000010,
    CS_MUL1 = 7'b0000100,
    CS_SQRT = 7'b0001000,
    CS_PREP = 7'b0010000,
    CS_DIV  = 7'b0100000,
    CS_DONE = 7'b1000000
  } cos_state_t;

  localparam logic [tkn_pkg::STEP_W-1:0] SQRT_LAST = tkn_pkg::STEP_W'(tkn_pkg::ROOT_W - 1);
  localparam logic [tkn_pkg::STEP_W-1:0] DIV_LAST  = tkn_pkg::STEP_W'(tkn_pkg::NUM_W - 1);
  localparam int HI_W = tkn_pkg::NORM_W - tkn_pkg::NB_LO_W;

  cos_state_t state_r, state_nxt;
  logic [tkn_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [tkn_pkg::NORM_W-1:0] na_r, na_nxt, nb_r, nb_nxt;
  logic [tkn_pkg::MAG_W-1:0]  mag_r, mag_nxt;
  logic                       neg_r, neg_nxt;
  logic [tkn_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [tkn_pkg::ROOT_W-1:0] root_r, root_nxt;
  logic [tkn_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [tkn_pkg::NUM_W-1:0]  num_r, num_nxt;
  logic [tkn_pkg::NUM_W-1:0]  quo_r, quo_nxt;
  logic [tkn_pkg::ROOT_W-1:0] div_r, div_nxt;

  logic [tkn_pkg::NORM_W+tkn_pkg::NB_LO_W-1:0] pp_lo;
  logic [tkn_pkg::NORM_W+HI_W-1:0]             pp_hi;
  logic [tkn_pkg::REM_W+1:0]                   sq_rem;
  logic [tkn_pkg::REM_W+1:0]                   sq_trial;
  logic [tkn_pkg::REM_W-1:0]                   dv_rem;
  logic [tkn_pkg::DOT_W-1:0]                   dot_abs;
  logic [tkn_pkg::DIST_W-1:0]                  quo_sat;

  assign pp_lo    = na_r * nb_r[tkn_pkg::NB_LO_W-1:0];
  assign pp_hi    = na_r * nb_r[tkn_pkg::NORM_W-1:tkn_pkg::NB_LO_W];
  assign sq_rem   = {rem_r, prod_r[tkn_pkg::PROD_W-1 -: 2]};
  assign sq_trial = (tkn_pkg::REM_W+2)'({root_r, 2'b01});
  assign dv_rem   = {rem_r[tkn_pkg::REM_W-2:0], num_r[tkn_pkg::NUM_W-1]};
  assign dot_abs  = dot[tkn_pkg::DOT_W-1] ? tkn_pkg::DOT_W'(-dot) : tkn_pkg::DOT_W'(dot);
  assign quo_sat  = (quo_r > tkn_pkg::NUM_W'(tkn_pkg::ONE_Q30)) ? tkn_pkg::ONE_Q30
                                                               : tkn_pkg::DIST_W'(quo_r);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    na_nxt    = na_r;
    nb_nxt    = nb_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    prod_nxt  = prod_r;
    root_nxt  = root_r;
    rem_nxt   = rem_r;
    num_nxt   = num_r;
    quo_nxt   = quo_r;
    div_nxt   = div_r;
    unique case (state_r)
      CS_IDLE: begin
        if (start) begin
          na_nxt    = norm_a;
          nb_nxt    = norm_b;
          neg_nxt   = dot[tkn_pkg::DOT_W-1];
          mag_nxt   = tkn_pkg::MAG_W'(dot_abs);
          state_nxt = CS_MUL0;
        end
      end
      CS_MUL0: begin
        prod_nxt  = tkn_pkg::PROD_W'(pp_lo);
        state_nxt = CS_MUL1;
      end
      CS_MUL1: begin
        prod_nxt  = prod_r + tkn_pkg::PROD_W'({pp_hi, {tkn_pkg::NB_LO_W{1'b0}}});
        root_nxt  = '0;
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = CS_SQRT;
      end
      CS_SQRT: begin
        // two radicand bits per step, one root bit out
        prod_nxt = {prod_r[tkn_pkg::PROD_W-3:0], 2'b00};
        if (sq_rem >= sq_trial) begin
          rem_nxt  = tkn_pkg::REM_W'(sq_rem - sq_trial);
          root_nxt = {root_r[tkn_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = tkn_pkg::REM_W'(sq_rem);
          root_nxt = {root_r[tkn_pkg::ROOT_W-2:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == SQRT_LAST) begin
          state_nxt = CS_PREP;
        end
      end
      CS_PREP: begin
        div_nxt   = (root_r < tkn_pkg::EPS_ROOT) ? tkn_pkg::EPS_ROOT : root_r;
        num_nxt   = {mag_r, 30'd0};
        rem_nxt   = '0;
        quo_nxt   = '0;
        step_nxt  = '0;
        state_nxt = CS_DIV;
      end
      CS_DIV: begin
        num_nxt = {num_r[tkn_pkg::NUM_W-2:0], 1'b0};
        if (dv_rem >= tkn_pkg::REM_W'(div_r)) begin
          rem_nxt = dv_rem - tkn_pkg::REM_W'(div_r);
          quo_nxt = {quo_r[tkn_pkg::NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = dv_rem;
          quo_nxt = {quo_r[tkn_pkg::NUM_W-2:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == DIV_LAST) begin
          state_nxt = CS_DONE;
        end
      end
      CS_DONE: begin
        state_nxt = CS_IDLE;
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    step_r <= step_nxt;
    na_r   <= na_nxt;
    nb_r   <= nb_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    prod_r <= prod_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    div_r  <= div_nxt;
  end

  assign done   = (state_r == CS_DONE);
  assign dist_o = neg_r ? (tkn_pkg::ONE_Q30 + quo_sat) : (tkn_pkg::ONE_Q30 - quo_sat);

endmodule

@@ hw/rtl/top_k_nearest_search.sv @@
// Top level of the top-k nearest neighbour search: accumulators, query memory, neighbour list
// Query element: written to query memory. Candidate element: query memory read on accept,
// then accumulate in ST_MAC. The last element then passes ST_FIN and ST_INS; cosine also
// waits in ST_COS on the digit-serial square root and long division (one bit each a cycle).
// Flush: one result per cycle while out_tready is high; an empty list gives one result.
// Synchronous active-low reset clears control, configuration, accumulators and the list;
// query memory is not cleared and holds undefined data until written.
module top_k_nearest_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // element_value[15:0], candidate_id[31:16]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // neighbor_id[15:0], neighbor_distance[47:16]
  output logic        out_tuser,  // found[0]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_wdata
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MAC   = 6'b000010,
    ST_FIN   = 6'b000100,
    ST_COS   = 6'b001000,
    ST_INS   = 6'b010000,
    ST_FLUSH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic                        metric_r;
  logic [tkn_pkg::K_W-1:0]     topk_r;
  logic [tkn_pkg::LEN_W-1:0]   len_r;
  logic [tkn_pkg::K_W-1:0]     k_eff;
  logic [tkn_pkg::LEN_W-1:0]   len_eff;

  logic [tkn_pkg::DIM_W-1:0]   cnt_r, cnt_nxt;
  logic [tkn_pkg::DIFF_W-1:0]  diff_r, diff_nxt;
  logic signed [tkn_pkg::DOT_W-1:0] dot_r, dot_nxt;
  logic [tkn_pkg::NORM_W-1:0]  qnorm_r, qnorm_nxt;
  logic [tkn_pkg::NORM_W-1:0]  cnorm_r, cnorm_nxt;

  logic [tkn_pkg::VAL_W-1:0]   qmem [tkn_pkg::MAX_DIM];
  logic signed [tkn_pkg::VAL_W-1:0] q_rd_r;
  logic signed [tkn_pkg::VAL_W-1:0] v_r;
  logic [tkn_pkg::ID_W-1:0]    id_r;
  logic                        end_r;
  logic [tkn_pkg::DIST_W-1:0]  ins_dist_r, ins_dist_nxt;

  logic                        in_acc;
  tkn_pkg::kind_t              kind;
  logic signed [tkn_pkg::VAL_W-1:0] v_in;
  logic [tkn_pkg::ID_W-1:0]    id_in;
  logic                        at_end;
  logic signed [31:0]          vv_in;
  logic signed [16:0]          d;
  logic signed [33:0]          dd;
  logic signed [31:0]          qv;
  logic signed [31:0]          vv;

  logic                        cos_start, cos_done;
  logic [tkn_pkg::DIST_W-1:0]  cos_dist;

  tkn_pkg::cell_ctrl_t         cell_ctrl;
  tkn_pkg::cell_out_t          cells [tkn_pkg::MAX_K];
  logic [tkn_pkg::MAX_K-1:0]   cell_valid;
  logic [tkn_pkg::MAX_K-1:0]   last_keep;
  logic                        reject;
  logic                        out_load;

  logic                        out_valid_r;
  logic [47:0]                 out_data_r;
  logic                        out_found_r;
  logic                        out_last_r;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign kind      = tkn_pkg::kind_t'(in_tuser);
  assign v_in      = in_tdata[15:0];
  assign id_in     = in_tdata[31:16];

  assign k_eff   = (topk_r == '0) ? tkn_pkg::K_W'(1) :
                   (topk_r > tkn_pkg::K_W'(tkn_pkg::MAX_K)) ? tkn_pkg::K_W'(tkn_pkg::MAX_K)
                                                            : topk_r;
  assign len_eff = (len_r == '0) ? tkn_pkg::LEN_W'(1) :
                   (len_r > tkn_pkg::LEN_W'(tkn_pkg::MAX_DIM)) ? tkn_pkg::LEN_W'(tkn_pkg::MAX_DIM)
                                                              : len_r;
  assign at_end  = (tkn_pkg::LEN_W'(cnt_r) + tkn_pkg::LEN_W'(1)) >= len_eff;

  assign vv_in = v_in * v_in;
  assign d     = 17'(q_rd_r) - 17'(v_r);
  assign dd    = d * d;
  assign qv    = q_rd_r * v_r;
  assign vv    = v_r * v_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= 1'b0;
      topk_r   <= tkn_pkg::K_W'(10);
      len_r    <= tkn_pkg::LEN_W'(128);
    end else if (cfg_we) begin
      unique case (cfg_index)
        tkn_pkg::REG_METRIC: metric_r <= cfg_wdata[0];
        tkn_pkg::REG_TOPK:   topk_r   <= cfg_wdata[tkn_pkg::K_W-1:0];
        tkn_pkg::REG_LEN:    len_r    <= cfg_wdata;
        default:             metric_r <= metric_r;
      endcase
    end
  end

  // query memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (in_acc && (kind == tkn_pkg::KIND_QUERY)) begin
      qmem[cnt_r] <= v_in;
    end
    if (in_acc && (kind == tkn_pkg::KIND_CAND)) begin
      q_rd_r <= qmem[cnt_r];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    diff_nxt     = diff_r;
    dot_nxt      = dot_r;
    qnorm_nxt    = qnorm_r;
    cnorm_nxt    = cnorm_r;
    ins_dist_nxt = ins_dist_r;
    cos_start    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (kind)
            tkn_pkg::KIND_QUERY: begin
              qnorm_nxt = ((cnt_r == '0) ? '0 : qnorm_r) + tkn_pkg::NORM_W'(vv_in[30:0]);
              // drop any partial candidate
              diff_nxt  = '0;
              dot_nxt   = '0;
              cnorm_nxt = '0;
              cnt_nxt   = at_end ? '0 : cnt_r + 1'b1;
            end
            tkn_pkg::KIND_CAND: begin
              cnt_nxt   = at_end ? '0 : cnt_r + 1'b1;
              state_nxt = ST_MAC;
            end
            tkn_pkg::KIND_FLUSH: begin
              state_nxt = ST_FLUSH;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_MAC: begin
        diff_nxt  = diff_r + tkn_pkg::DIFF_W'(dd[32:0]);
        dot_nxt   = dot_r + tkn_pkg::DOT_W'(qv);
        cnorm_nxt = cnorm_r + tkn_pkg::NORM_W'(vv[30:0]);
        state_nxt = end_r ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        if (metric_r) begin
          cos_start = 1'b1;
          state_nxt = ST_COS;
        end else begin
          ins_dist_nxt = (diff_r > tkn_pkg::DIFF_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                   : diff_r[31:0];
          state_nxt    = ST_INS;
        end
      end
      ST_COS: begin
        if (cos_done) begin
          ins_dist_nxt = cos_dist;
          state_nxt    = ST_INS;
        end
      end
      ST_INS: begin
        diff_nxt  = '0;
        dot_nxt   = '0;
        cnorm_nxt = '0;
        state_nxt = ST_IDLE;
      end
      ST_FLUSH: begin
        if (out_load && !(cell_valid[0] && cell_valid[1])) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      diff_r  <= '0;
      dot_r   <= '0;
      qnorm_r <= '0;
      cnorm_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      diff_r  <= diff_nxt;
      dot_r   <= dot_nxt;
      qnorm_r <= qnorm_nxt;
      cnorm_r <= cnorm_nxt;
    end
    ins_dist_r <= ins_dist_nxt;
    if (in_acc) begin
      v_r   <= v_in;
      id_r  <= id_in;
      end_r <= at_end;
    end
  end

  tkn_cos u_cos (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cos_start),
    .norm_a (qnorm_r),
    .norm_b (cnorm_r),
    .dot    (dot_r),
    .done   (cos_done),
    .dist_o (cos_dist)
  );

  // neighbour list
  assign reject         = |last_keep;
  assign out_load       = (state_r == ST_FLUSH) && (!out_valid_r || out_tready);
  assign cell_ctrl.ins  = (state_r == ST_INS) && !reject;
  assign cell_ctrl.trim = (state_r == ST_INS) || (in_acc && (kind == tkn_pkg::KIND_FLUSH));
  assign cell_ctrl.pop  = out_load && cell_valid[0];

  for (genvar i = 0; i < tkn_pkg::MAX_K; i++) begin : g_cell
    tkn_pkg::cell_out_t left_in, right_in;
    logic               beyond;

    if (i == 0) begin : g_head
      assign left_in = '{valid: 1'b1, keep: 1'b1, id: '0, dst: '0};
    end else begin : g_mid
      assign left_in = cells[i-1];
    end
    if (i == tkn_pkg::MAX_K - 1) begin : g_tail
      assign right_in = '0;
    end else begin : g_body
      assign right_in = cells[i+1];
    end

    assign beyond       = tkn_pkg::K_W'(i) >= k_eff;
    assign last_keep[i] = (tkn_pkg::K_W'(i) == (k_eff - 1'b1)) && cells[i].keep;
    assign cell_valid[i] = cells[i].valid;

    tkn_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl),
      .beyond_k (beyond),
      .new_id   (id_r),
      .new_dist (ins_dist_r),
      .left     (left_in),
      .right    (right_in),
      .cell_o   (cells[i])
    );
  end

  // result register; hold while the sink stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      if (cell_valid[0]) begin
        out_data_r  <= {cells[0].dst, cells[0].id};
        out_found_r <= 1'b1;
        out_last_r  <= !cell_valid[1];
      end else begin
        out_data_r  <= '0;
        out_found_r <= 1'b0;
        out_last_r  <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;

  a_list_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid + 64'd1) & cell_valid) == 64'd0)
    else $error("neighbour list valid bits not contiguous");

  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && state_nxt == ST_IDLE) |=> !cell_valid[0])
    else $error("list not empty after flush");

  a_cos_done: assert property (@(posedge clk) disable iff (!rst_n)
    cos_done |-> (state_r == ST_COS))
    else $error("cosine result outside its wait");

endmodule
